[sv/pcpa_pkg.sv]
// Shared types, constants and codes of the paged chunk pool allocator.
package pcpa_pkg;

   localparam int MaxPages       = 16;
   localparam int MaxChunks      = 64;
   localparam int TotalChunks    = MaxPages * MaxChunks;
   localparam int SlotW          = $clog2(MaxPages);
   localparam int ChunkW         = $clog2(MaxChunks);
   localparam int IdW            = SlotW + ChunkW;
   localparam int NodeW          = IdW + 1;
   localparam int PageNodeW      = SlotW + 1;
   localparam int CapW           = 7;
   localparam int TallyW         = 7;
   localparam logic [TallyW-1:0] TallyLimit = TallyW'(2 * MaxChunks - 1);

   typedef enum logic [1:0] {
      ACT_ACQUIRE = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_SHRINK  = 2'd2,
      ACT_CLEAN   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NO_PAGES = 2'd1,
      STS_FOREIGN  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_FILL, S_POP_RD, S_POP_WB,
      S_CNT_RD, S_CNT_WB, S_UNL_RD, S_UNL_WB, S_PG, S_RESP
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_START, OP_FILL, OP_FILL_LAST, OP_POP_RD, OP_POP_WB,
      OP_NO_PAGE, OP_FREE, OP_CLEAN, OP_SHR_INIT, OP_CNT_RD, OP_CNT_WB,
      OP_UNL_INIT, OP_UNL_RD, OP_UNL_WB, OP_PG_INIT, OP_PG_STEP
   } op_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       head_empty;
      logic       slot_found;
      logic       fill_last;
      logic       walk_end;
      logic       page_end;
   } dp_stat_type;

endpackage

[sv/paged_chunk_pool_allocator_core.sv]
// Top level of the paged chunk pool allocator.
//
// A request is taken when start is high and busy is low; exactly one result word
// follows, shown for one cycle with rsp_valid, and the receiver must take it then.
// Free and clean are settled in the decode state. Acquire pops the head of the free
// list with one read of the link memory when the list holds a chunk, and otherwise
// claims a free page slot and writes each chunk link of the new page in its own
// cycle. Shrink walks the free list twice, to tally the free chunks of each page and
// to unlink those of full pages, then the page list at one page per cycle. The
// page_capacity register takes writes at any time but should only be changed while
// busy is low.
module paged_chunk_pool_allocator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [3:0] req_page_slot,
   input  logic [5:0] req_chunk_index,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_granted_page,
   output logic [5:0] rsp_granted_chunk,
   output logic [4:0] rsp_pages_in_use,
   output logic [4:0] rsp_pages_released,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);
   import pcpa_pkg::*;

   op_type      op;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   // Sequencer.
   pcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .op        (op),
      .stat      (stat)
   );

   // Storage and arithmetic.
   pcpa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .stat               (stat),
      .req_action         (req_action),
      .req_page_slot      (req_page_slot),
      .req_chunk_index    (req_chunk_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .rsp_status         (rsp_status),
      .rsp_granted_page   (rsp_granted_page),
      .rsp_granted_chunk  (rsp_granted_chunk),
      .rsp_pages_in_use   (rsp_pages_in_use),
      .rsp_pages_released (rsp_pages_released)
   );

endmodule

[sv/pcpa_ctrl.sv]
// Controller state machine of the paged chunk pool allocator.
module pcpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output pcpa_pkg::op_type     op,
   input  pcpa_pkg::dp_stat_type stat
);
   import pcpa_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_ACQUIRE: begin
                  if (!stat.head_empty) state_in = S_POP_RD;
                  else if (stat.slot_found) state_in = S_FILL;
                  else state_in = S_RESP;
               end
               ACT_SHRINK: state_in = S_CNT_RD;
               default: state_in = S_RESP;
            endcase
         end
         S_FILL: begin
            if (stat.fill_last) state_in = S_RESP;
         end
         S_POP_RD: state_in = S_POP_WB;
         S_POP_WB: state_in = S_RESP;
         S_CNT_RD: state_in = stat.walk_end ? S_UNL_RD : S_CNT_WB;
         S_CNT_WB: state_in = S_CNT_RD;
         S_UNL_RD: state_in = stat.walk_end ? S_PG : S_UNL_WB;
         S_UNL_WB: state_in = S_UNL_RD;
         S_PG: begin
            if (stat.page_end) state_in = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      op        = OP_NONE;
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
      unique case (state_ff)
         S_IDLE: begin
            if (start) op = OP_START;
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_ACQUIRE: begin
                  if (!stat.head_empty) op = OP_NONE;
                  else if (!stat.slot_found) op = OP_NO_PAGE;
               end
               ACT_FREE:   op = OP_FREE;
               ACT_SHRINK: op = OP_SHR_INIT;
               default:    op = OP_CLEAN;
            endcase
         end
         S_FILL:   op = stat.fill_last ? OP_FILL_LAST : OP_FILL;
         S_POP_RD: op = OP_POP_RD;
         S_POP_WB: op = OP_POP_WB;
         S_CNT_RD: op = stat.walk_end ? OP_UNL_INIT : OP_CNT_RD;
         S_CNT_WB: op = OP_CNT_WB;
         S_UNL_RD: op = stat.walk_end ? OP_PG_INIT : OP_UNL_RD;
         S_UNL_WB: op = OP_UNL_WB;
         S_PG: begin
            if (!stat.page_end) op = OP_PG_STEP;
         end
         default: op = OP_NONE;
      endcase
   end

endmodule

[sv/pcpa_dp.sv]
// Datapath of the paged chunk pool allocator: link memory, page lists and results.
module pcpa_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pcpa_pkg::op_type       op,
   output pcpa_pkg::dp_stat_type  stat,
   input  logic [1:0]             req_action,
   input  logic [3:0]             req_page_slot,
   input  logic [5:0]             req_chunk_index,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [6:0]             csr_data,
   output logic [1:0]             rsp_status,
   output logic [3:0]             rsp_granted_page,
   output logic [5:0]             rsp_granted_chunk,
   output logic [4:0]             rsp_pages_in_use,
   output logic [4:0]             rsp_pages_released
);
   import pcpa_pkg::*;

   // Chunk link memory: next free chunk as id+1, zero ends the list.
   logic [NodeW-1:0] link_mem [0:TotalChunks-1];
   logic [NodeW-1:0] rd_data_ff;
   logic             rd_en;
   logic [IdW-1:0]   rd_addr;
   logic             wr_en;
   logic [IdW-1:0]   wr_addr;
   logic [NodeW-1:0] wr_data;

   logic [1:0]          act_ff;
   logic [SlotW-1:0]    slot_ff;
   logic [ChunkW-1:0]   idx_ff;
   logic [CapW-1:0]     cap_ff;
   logic [CapW-1:0]     cap;
   logic [NodeW-1:0]    head_ff;
   logic [PageNodeW-1:0] page_head_ff;
   logic [PageNodeW-1:0] page_links_ff [MaxPages];
   logic [MaxPages-1:0] used_ff;
   logic [4:0]          count_ff;
   logic [TallyW-1:0]   tally_ff [MaxPages];
   logic [NodeW-1:0]    node_ff;
   logic [NodeW-1:0]    prev_ff;
   logic [NodeW-1:0]    steps_ff;
   logic [ChunkW-1:0]   fill_ff;
   logic [1:0]          status_ff;
   logic [SlotW-1:0]    gpage_ff;
   logic [ChunkW-1:0]   gchunk_ff;
   logic [4:0]          rel_ff;

   logic [SlotW-1:0]    free_slot;
   logic                slot_found;
   logic [IdW-1:0]      node_id;
   logic [IdW-1:0]      head_id;
   logic [SlotW-1:0]    node_slot;
   logic                node_owned;
   logic                node_full;
   logic [SlotW-1:0]    pg_slot;
   logic [PageNodeW-1:0] pg_next;
   logic                pg_full;
   logic [4:0]          used_total;
   logic [IdW-1:0]      fill_addr;
   logic [NodeW-1:0]    base_node;

   // Effective capacity, clamped to between one chunk and one page's span.
   always_comb begin
      if (cap_ff == '0) cap = CapW'(1);
      else if (cap_ff > CapW'(MaxChunks)) cap = CapW'(MaxChunks);
      else cap = cap_ff;
   end

   // Lowest free page slot.
   always_comb begin
      free_slot  = '0;
      slot_found = 1'b0;
      for (int s = MaxPages - 1; s >= 0; s--) begin
         if (!used_ff[s]) begin
            free_slot  = SlotW'(s);
            slot_found = 1'b1;
         end
      end
   end

   // Number of held pages, for clean.
   always_comb begin
      used_total = '0;
      for (int s = 0; s < MaxPages; s++) begin
         used_total = used_total + {4'd0, used_ff[s]};
      end
   end

   // Ownership of the chunk under the walk pointer.
   assign node_id    = IdW'(node_ff - NodeW'(1));
   assign head_id    = IdW'(head_ff - NodeW'(1));
   assign node_slot  = node_id[IdW-1:ChunkW];
   assign node_owned = used_ff[node_slot] && ({1'b0, node_id[ChunkW-1:0]} < cap);
   assign node_full  = node_owned && (tally_ff[node_slot] == cap);

   // Page walk view.
   assign pg_slot = SlotW'(node_ff - NodeW'(1));
   assign pg_next = page_links_ff[pg_slot];
   assign pg_full = used_ff[pg_slot] && (tally_ff[pg_slot] == cap);

   assign fill_addr = {free_slot, fill_ff};
   assign base_node = NodeW'({free_slot, {ChunkW{1'b0}}});

   // Status to the controller.
   always_comb begin
      stat.action     = action_type'(act_ff);
      stat.head_empty = (head_ff == '0);
      stat.slot_found = slot_found;
      stat.fill_last  = ({1'b0, fill_ff} + CapW'(1) == cap);
      stat.walk_end   = (node_ff == '0) || (steps_ff == NodeW'(TotalChunks));
      stat.page_end   = (node_ff == '0) || (node_ff > NodeW'(MaxPages))
                        || (steps_ff == NodeW'(MaxPages));
   end

   // Memory port control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = node_id;
      wr_en   = 1'b0;
      wr_addr = fill_addr;
      wr_data = '0;
      unique case (op)
         OP_POP_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_id;
         end
         OP_CNT_RD, OP_UNL_RD: rd_en = 1'b1;
         OP_FILL: begin
            wr_en   = 1'b1;
            wr_data = base_node + NodeW'(fill_ff) + NodeW'(2);
         end
         OP_FILL_LAST: wr_en = 1'b1;
         OP_FREE: begin
            wr_en   = used_ff[slot_ff] && ({1'b0, idx_ff} < cap);
            wr_addr = {slot_ff, idx_ff};
            wr_data = head_ff;
         end
         OP_UNL_WB: begin
            wr_en   = node_full && (prev_ff != '0);
            wr_addr = IdW'(prev_ff - NodeW'(1));
            wr_data = rd_data_ff;
         end
         default: ;
      endcase
   end

   // Link memory.
   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= link_mem[rd_addr];
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapW'(MaxChunks);
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // Allocator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         page_head_ff <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
      end else begin
         unique case (op)
            OP_FILL_LAST: begin
               head_ff                  <= (cap > CapW'(1)) ? base_node + NodeW'(2) : '0;
               page_links_ff[free_slot] <= page_head_ff;
               page_head_ff             <= PageNodeW'(free_slot) + PageNodeW'(1);
               used_ff[free_slot]       <= 1'b1;
               count_ff                 <= count_ff + 5'd1;
            end
            OP_POP_WB: head_ff <= rd_data_ff;
            OP_FREE: begin
               if (used_ff[slot_ff] && ({1'b0, idx_ff} < cap)) begin
                  head_ff <= NodeW'({slot_ff, idx_ff}) + NodeW'(1);
               end
            end
            OP_CLEAN: begin
               head_ff      <= '0;
               page_head_ff <= '0;
               used_ff      <= '0;
               count_ff     <= '0;
            end
            OP_UNL_WB: begin
               if (node_full && prev_ff == '0) head_ff <= rd_data_ff;
            end
            OP_PG_STEP: begin
               if (pg_full) begin
                  used_ff[pg_slot] <= 1'b0;
                  if (count_ff != '0) count_ff <= count_ff - 5'd1;
                  if (prev_ff != '0 && prev_ff <= NodeW'(MaxPages)) begin
                     page_links_ff[SlotW'(prev_ff - NodeW'(1))] <= pg_next;
                  end else begin
                     page_head_ff <= pg_next;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Request latch, walk pointers, tallies and result words.
   always_ff @(posedge clock) begin
      unique case (op)
         OP_START: begin
            act_ff    <= req_action;
            slot_ff   <= req_page_slot;
            idx_ff    <= req_chunk_index;
            fill_ff   <= '0;
            status_ff <= STS_OK;
            gpage_ff  <= '0;
            gchunk_ff <= '0;
            rel_ff    <= '0;
         end
         OP_FILL: fill_ff <= fill_ff + ChunkW'(1);
         OP_FILL_LAST: gpage_ff <= free_slot;
         OP_NO_PAGE: status_ff <= STS_NO_PAGES;
         OP_POP_WB: begin
            gpage_ff  <= head_id[IdW-1:ChunkW];
            gchunk_ff <= head_id[ChunkW-1:0];
         end
         OP_FREE: begin
            if (!(used_ff[slot_ff] && ({1'b0, idx_ff} < cap))) status_ff <= STS_FOREIGN;
         end
         OP_CLEAN: rel_ff <= used_total;
         OP_SHR_INIT: begin
            for (int s = 0; s < MaxPages; s++) tally_ff[s] <= '0;
            node_ff  <= head_ff;
            steps_ff <= '0;
         end
         OP_CNT_WB: begin
            if (node_owned && tally_ff[node_slot] < TallyLimit) begin
               tally_ff[node_slot] <= tally_ff[node_slot] + TallyW'(1);
            end
            node_ff  <= rd_data_ff;
            steps_ff <= steps_ff + NodeW'(1);
         end
         OP_UNL_INIT: begin
            node_ff  <= head_ff;
            prev_ff  <= '0;
            steps_ff <= '0;
         end
         OP_UNL_WB: begin
            if (!node_full) prev_ff <= node_ff;
            node_ff  <= rd_data_ff;
            steps_ff <= steps_ff + NodeW'(1);
         end
         OP_PG_INIT: begin
            node_ff  <= NodeW'(page_head_ff);
            prev_ff  <= '0;
            steps_ff <= '0;
         end
         OP_PG_STEP: begin
            if (pg_full) rel_ff <= rel_ff + 5'd1;
            else prev_ff <= node_ff;
            node_ff  <= NodeW'(pg_next);
            steps_ff <= steps_ff + NodeW'(1);
         end
         default: ;
      endcase
   end

   assign rsp_status         = status_ff;
   assign rsp_granted_page   = gpage_ff;
   assign rsp_granted_chunk  = gchunk_ff;
   assign rsp_pages_in_use   = count_ff;
   assign rsp_pages_released = rel_ff;

   // The page counter always matches the held-page flags.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == 5'($countones(used_ff)))
      else $error("page counter out of step with held pages");

   // The free list head never points past the last chunk.
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NodeW'(TotalChunks))
      else $error("free list head out of range");

   // A page claim always leaves that slot held.
   a_claim_holds: assert property (@(posedge clock) disable iff (reset)
      op == OP_FILL_LAST |=> used_ff[$past(free_slot)])
      else $error("claimed page not marked held");

endmodule
